// ===== rtl/core/tsc_pkg.sv =====
// shared types and constants for the toy spn counter-mode byte cipher
package tsc_pkg;

    // register indexes on the configuration port
    typedef enum logic [7:0] {
        REG_SBOX_TABLE      = 8'd0,
        REG_BIT_PERMUTATION = 8'd1,
        REG_ROUND_KEYS      = 8'd2,
        REG_START_COUNTER   = 8'd3
    } reg_index_t;

    localparam int CFG_DATA_W = 64;
    localparam int BYTE_W     = 8;

    // reset values: identity s-box and identity permutation
    localparam logic [63:0] SBOX_RESET = 64'hFEDC_BA98_7654_3210;
    localparam logic [23:0] PERM_RESET = 24'hFA_C688;
    localparam logic [31:0] KEYS_RESET = 32'h0000_0000;
    localparam logic [7:0]  START_RESET = 8'h00;

    // live configuration seen by the datapath
    typedef struct packed {
        logic [63:0] sbox_table;
        logic [23:0] bit_permutation;
        logic [31:0] round_keys;
        logic [7:0]  start_counter;
    } cfg_t;

endpackage

// ===== rtl/core/toy_spn_ctr_byte_cipher.sv =====
// top level of the toy spn counter-mode byte cipher
//
// Each accepted word carries one message byte and returns one cipher byte,
// the message byte XOR the SPN encryption of an 8-bit counter. The counter
// loads from start_counter on a byte flagged first_of_message, otherwise it
// continues from the previous byte (0 after reset), wrapping at 256. One
// byte is taken every cycle while in_stall is low; the input register holds
// the byte and its counter while the ROUNDS combinational rounds run, and
// the output register captures the result once it is free. Stall from the
// output side propagates back to the input in the same cycle. The user must
// write Configuration through cfg_write/cfg_index/cfg_data only while no word
// is in flight; the block itself does not enforce this.
module toy_spn_ctr_byte_cipher
    import tsc_pkg::*;
#(
    parameter int ROUNDS = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [7:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            plain_byte,
    input  logic                  first_of_message,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            cipher_byte
);

    cfg_t cfg;

    logic             in_accept;
    logic             s1_advance;
    logic             out_free;
    logic [7:0]       ctr_used;
    logic [7:0]       counter_reg;
    logic [7:0]       counter_next;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [7:0]       s1_plain_reg;
    logic [7:0]       s1_ctr_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       cipher_reg;
    logic [7:0]       keystream;
    logic [7:0]       chain [ROUNDS+1];

    tsc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // handshake: output register frees when empty or taken
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign in_accept  = in_valid && !in_stall;

    // counter for this word and the next one
    assign ctr_used     = first_of_message ? cfg.start_counter : counter_reg;
    assign counter_next = in_accept ? ctr_used + 8'd1 : counter_reg;

    assign s1_valid_next  = in_accept || (s1_valid_reg && !s1_advance);
    assign out_valid_next = s1_advance || (out_valid_reg && out_stall);

    // round chain on the registered counter
    assign chain[0] = s1_ctr_reg;
    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        localparam int KEY_SEL = r % 4;
        tsc_round u_round (
            .data_in         (chain[r]),
            .round_key       (cfg.round_keys[8*KEY_SEL +: 8]),
            .sbox_table      (cfg.sbox_table),
            .bit_permutation (cfg.bit_permutation),
            .data_out        (chain[r+1])
        );
    end

    // final key mix
    localparam int FINAL_SEL = ROUNDS % 4;
    assign keystream = chain[ROUNDS] ^ cfg.round_keys[8*FINAL_SEL +: 8];

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= 8'd0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            counter_reg   <= counter_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_plain_reg <= plain_byte;
            s1_ctr_reg   <= ctr_used;
        end
        if (s1_advance)
        begin
            cipher_reg <= s1_plain_reg ^ keystream;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cipher_byte = cipher_reg;

endmodule

// ===== rtl/core/tsc_cfg_regs.sv =====
// configuration register file for the byte cipher
module tsc_cfg_regs
    import tsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [7:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // decode a write; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SBOX_TABLE:      cfg_next.sbox_table      = cfg_data;
                REG_BIT_PERMUTATION: cfg_next.bit_permutation = cfg_data[23:0];
                REG_ROUND_KEYS:      cfg_next.round_keys      = cfg_data[31:0];
                REG_START_COUNTER:   cfg_next.start_counter   = cfg_data[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sbox_table      <= SBOX_RESET;
            cfg_reg.bit_permutation <= PERM_RESET;
            cfg_reg.round_keys      <= KEYS_RESET;
            cfg_reg.start_counter   <= START_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/tsc_round.sv =====
// one spn round: key mix, nibble substitution, bit permutation
module tsc_round
    import tsc_pkg::*;
(
    input  logic [BYTE_W-1:0] data_in,
    input  logic [BYTE_W-1:0] round_key,
    input  logic [63:0]       sbox_table,
    input  logic [23:0]       bit_permutation,
    output logic [BYTE_W-1:0] data_out
);

    logic [BYTE_W-1:0] mixed;
    logic [BYTE_W-1:0] subbed;

    // key mix
    assign mixed = data_in ^ round_key;

    // both nibbles through the s-box
    assign subbed[7:4] = sbox_table[{mixed[7:4], 2'b00} +: 4];
    assign subbed[3:0] = sbox_table[{mixed[3:0], 2'b00} +: 4];

    // output bit i takes the input bit named by entry i
    always_comb
    begin
        for (int i = 0; i < BYTE_W; i++)
        begin
            data_out[i] = subbed[bit_permutation[3*i +: 3]];
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// testbench for the toy spn counter-mode byte cipher: stimulus, predictor and checker
module tb_top;
    import tsc_pkg::*;

    localparam int SPN_ROUNDS   = 3;
    localparam int IDLE_PCT     = 28;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_SETS  = 8;
    localparam int SET_WORDS    = 60;

    // register indexes outside the map, writes there must be ignored
    localparam logic [7:0] REG_UNMAPPED_LO = 8'd4;
    localparam logic [7:0] REG_UNMAPPED_HI = 8'd255;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } msg_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [7:0]            cfg_index = 8'd0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            plain_byte = 8'd0;
    logic                  first_of_message = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            cipher_byte;

    // stimulus control
    logic calm = 1'b0;
    logic hold_req = 1'b0;
    logic hold_taken;
    int   hold_left;

    // predictor copy of configuration and counter
    logic [63:0] sbox_copy = SBOX_RESET;
    logic [23:0] perm_copy = PERM_RESET;
    logic [31:0] keys_copy = KEYS_RESET;
    logic [7:0]  start_copy = START_RESET;
    logic [7:0]  ctr_copy = 8'd0;

    msg_word_t  pending_words[$];
    logic [7:0] cipher_expect[$];
    msg_word_t  next_word;
    int         words_in_flight = 0;
    int         fail_count = 0;

    toy_spn_ctr_byte_cipher #(.ROUNDS(SPN_ROUNDS)) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .plain_byte       (plain_byte),
        .first_of_message (first_of_message),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .cipher_byte      (cipher_byte)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("tb: mismatch: %s", what);
        fail_count++;
    endtask

    // one spn encryption of a counter value under the current configuration
    function automatic logic [7:0] spn_encrypt(input logic [7:0] blk);
        logic [7:0] v;
        logic [7:0] s;
        logic [7:0] p;
        v = blk;
        for (int r = 0; r < SPN_ROUNDS; r++)
        begin
            v = v ^ keys_copy[8 * (r % 4) +: 8];
            s = {sbox_copy[4 * v[7:4] +: 4], sbox_copy[4 * v[3:0] +: 4]};
            for (int i = 0; i < 8; i++)
                p[i] = s[perm_copy[3 * i +: 3]];
            v = p;
        end
        return v ^ keys_copy[8 * (SPN_ROUNDS % 4) +: 8];
    endfunction

    // counter tracking and expected cipher byte for an accepted word
    task automatic track_word(input logic [7:0] data, input logic first);
        if (first)
            ctr_copy = start_copy;
        cipher_expect.push_back(data ^ spn_encrypt(ctr_copy));
        ctr_copy = ctr_copy + 8'd1;
    endtask

    // driver: holds a stalled word, otherwise offers the next pending word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            plain_byte <= 8'd0;
            first_of_message <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                track_word(plain_byte, first_of_message);
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    plain_byte <= next_word.data;
                    first_of_message <= next_word.first;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each cipher word and drives the output stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_taken <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (cipher_expect.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected cipher_byte %02h", cipher_byte));
                end
                else
                begin
                    if (cipher_byte !== cipher_expect[0])
                        report_mismatch($sformatf("cipher_byte got %02h want %02h",
                                                  cipher_byte, cipher_expect[0]));
                    void'(cipher_expect.pop_front());
                    words_in_flight--;
                end
            end
            // long hold once, otherwise random stalls unless calm
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (hold_req && !hold_taken)
            begin
                out_stall <= 1'b1;
                hold_left <= LONG_HOLD - 1;
                hold_taken <= 1'b1;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    task automatic add_word(input logic [7:0] data, input logic first);
        pending_words.push_back('{data: data, first: first});
        words_in_flight++;
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [63:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_SBOX_TABLE:      sbox_copy = data;
            REG_BIT_PERMUTATION: perm_copy = data[23:0];
            REG_ROUND_KEYS:      keys_copy = data[31:0];
            REG_START_COUNTER:   start_copy = data[7:0];
            default:             ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // sender waits until every expected word is back, then lets the pipe settle
    task automatic wait_drained();
        while (words_in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly random, sometimes all zeros or all ones
    function automatic logic [63:0] pick_value();
        int sel;
        sel = $urandom_range(0, 5);
        if (sel == 0)
            return 64'd0;
        if (sel == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic random_config();
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_SBOX_TABLE, pick_value());
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_BIT_PERMUTATION, pick_value());
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_ROUND_KEYS, pick_value());
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_START_COUNTER, pick_value());
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_UNMAPPED_LO + 8'($urandom_range(0, 251)), pick_value());
    endtask

    // mostly whole messages, some loose words with random start flags
    task automatic random_words();
        int count;
        int len;
        count = 0;
        while (count < SET_WORDS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                len = $urandom_range(1, 24);
                add_word(8'($urandom), 1'b1);
                for (int i = 1; i < len; i++)
                    add_word(8'($urandom), 1'b0);
            end
            else
            begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    add_word(8'($urandom), 1'($urandom_range(0, 1)));
            end
            count += len;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration, counter running from zero, then restarted by a message start
        add_word(8'h00, 1'b0);
        add_word(8'hFF, 1'b0);
        add_word(8'hA5, 1'b0);
        add_word(8'h5A, 1'b0);
        add_word(8'hFF, 1'b1);
        add_word(8'h00, 1'b0);
        add_word(8'h0F, 1'b0);
        wait_drained();

        // nonzero keys, counter wrap, unmapped indexes ignored
        write_reg(REG_SBOX_TABLE, 64'h3A5F_0C81_96E2_B7D4);
        write_reg(REG_BIT_PERMUTATION, 64'h0000_0000_0053_9CB1);
        write_reg(REG_ROUND_KEYS, 64'h0000_0000_8C3A_51E7);
        write_reg(REG_START_COUNTER, 64'h0000_0000_0000_00FE);
        write_reg(REG_UNMAPPED_LO, '1);
        write_reg(REG_UNMAPPED_HI, '1);
        add_word(8'h00, 1'b1);
        add_word(8'h11, 1'b0);
        add_word(8'h22, 1'b0);
        add_word(8'h33, 1'b0);
        add_word(8'hC3, 1'b1);
        wait_drained();

        // all permutation entries pick bit zero, all-ones tables
        write_reg(REG_BIT_PERMUTATION, 64'd0);
        write_reg(REG_SBOX_TABLE, '1);
        write_reg(REG_ROUND_KEYS, 64'h0000_0000_FFFF_FFFF);
        write_reg(REG_START_COUNTER, 64'h0000_0000_0000_00FF);
        add_word(8'h80, 1'b1);
        add_word(8'h7F, 1'b0);
        add_word(8'hFF, 1'b1);
        wait_drained();

        // all permutation entries pick bit seven, zero tables
        write_reg(REG_BIT_PERMUTATION, 64'h0000_0000_00FF_FFFF);
        write_reg(REG_SBOX_TABLE, 64'd0);
        write_reg(REG_ROUND_KEYS, 64'd0);
        write_reg(REG_START_COUNTER, 64'd0);
        add_word(8'h01, 1'b0);
        add_word(8'hFE, 1'b1);
        wait_drained();

        // random sets, one with a long output hold, one with no idling
        for (int ph = 0; ph < RANDOM_SETS; ph++)
        begin
            random_config();
            if (ph == 1)
                hold_req <= 1'b1;
            if (ph == 3)
                calm <= 1'b1;
            random_words();
            wait_drained();
            if (ph == 3)
                calm <= 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (cipher_expect.size() != 0)
            report_mismatch($sformatf("%0d cipher words never arrived", cipher_expect.size()));
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit
    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule
